// File: src/lfos_pkg.sv
// ---------------------------------------------------------------------------
// lfos_pkg
// Shared types and constants of the line-follow and obstacle sequencer.
// ---------------------------------------------------------------------------
package lfos_pkg;

   localparam int DUTY_W   = 16;
   localparam int SENSE_W  = 24;
   localparam int CTICK_W  = 12;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   // item modes
   localparam logic [1:0] MODE_LINE = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_BUMP = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // led colors
   localparam logic [1:0] LED_OFF   = 2'd0;
   localparam logic [1:0] LED_RED   = 2'd1;
   localparam logic [1:0] LED_GREEN = 2'd2;
   localparam logic [1:0] LED_BLUE  = 2'd3;

   // manoeuvre phases
   localparam logic [2:0] PH_BACKUP     = 3'd0;
   localparam logic [2:0] PH_TURN_R1    = 3'd1;
   localparam logic [2:0] PH_STRAIGHT1  = 3'd2;
   localparam logic [2:0] PH_TURN_L1    = 3'd3;
   localparam logic [2:0] PH_LONG       = 3'd4;
   localparam logic [2:0] PH_TURN_L2    = 3'd5;
   localparam logic [2:0] PH_STRAIGHT2  = 3'd6;
   localparam logic [2:0] PH_TURN_R2    = 3'd7;

   // register indexes
   localparam logic [2:0] REG_FAST_DUTY     = 3'd0;
   localparam logic [2:0] REG_SLOW_DUTY     = 3'd1;
   localparam logic [2:0] REG_RIGHT_NORMAL  = 3'd2;
   localparam logic [2:0] REG_LEFT_NORMAL   = 3'd3;
   localparam logic [2:0] REG_BLACK_THRESH  = 3'd4;
   localparam logic [2:0] REG_STRAIGHT      = 3'd5;
   localparam logic [2:0] REG_TURN          = 3'd6;
   localparam logic [2:0] REG_LONG_STRAIGHT = 3'd7;

   // length adjustments of the later phases
   localparam logic [CTICK_W-1:0] TURN_TRIM     = CTICK_W'(25);
   localparam logic [CTICK_W-1:0] STRAIGHT_TRIM = CTICK_W'(50);

   typedef enum logic {
      ST_IDLE,
      ST_MANEUVER
   } ctl_state_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  fast_duty;
      logic [DUTY_W-1:0]  slow_duty;
      logic [DUTY_W-1:0]  right_normal_duty;
      logic [DUTY_W-1:0]  left_normal_duty;
      logic [SENSE_W-1:0] black_threshold;
      logic [CTICK_W-1:0] straight_ticks;
      logic [CTICK_W-1:0] turn_ticks;
      logic [CTICK_W-1:0] long_straight_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [SENSE_W-1:0] right_sensor_count;
      logic [SENSE_W-1:0] left_sensor_count;
   } item_type;

   typedef struct packed {
      logic [DUTY_W-1:0] right_duty;
      logic [DUTY_W-1:0] left_duty;
      logic              right_reverse;
      logic              left_reverse;
      logic [1:0]        led_color;
      logic              maneuver_active;
      logic [2:0]        phase;
   } result_type;

   // wheel directions and led of a manoeuvre phase
   function automatic logic [3:0] phase_drive(input logic [2:0] p);
      logic [3:0] d;
      unique case (p)
         PH_BACKUP:               d = {1'b1, 1'b1, LED_OFF};
         PH_TURN_R1, PH_TURN_R2:  d = {1'b0, 1'b1, LED_GREEN};
         PH_TURN_L1, PH_TURN_L2:  d = {1'b1, 1'b0, LED_RED};
         default:                 d = {1'b0, 1'b0, LED_OFF};
      endcase
      return d;
   endfunction

endpackage

// File: src/lfos_csr.sv
// ---------------------------------------------------------------------------
// lfos_csr
// Configuration registers behind a simple APB-style slave.
// ---------------------------------------------------------------------------
module lfos_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [lfos_pkg::CSR_AW-1:0] paddr,
   input  logic [lfos_pkg::CSR_DW-1:0] pwdata,
   output logic [lfos_pkg::CSR_DW-1:0] prdata,
   output logic                       pready,
   output lfos_pkg::cfg_type          cfg
);
   import lfos_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_AW-1:2];
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_duty           <= DUTY_W'(300);
         cfg_ff.slow_duty           <= DUTY_W'(100);
         cfg_ff.right_normal_duty   <= DUTY_W'(165);
         cfg_ff.left_normal_duty    <= DUTY_W'(160);
         cfg_ff.black_threshold     <= SENSE_W'(1000);
         cfg_ff.straight_ticks      <= CTICK_W'(500);
         cfg_ff.turn_ticks          <= CTICK_W'(190);
         cfg_ff.long_straight_ticks <= CTICK_W'(1000);
      end else if (wr_en) begin
         unique case (idx)
            REG_FAST_DUTY:     cfg_ff.fast_duty           <= pwdata[DUTY_W-1:0];
            REG_SLOW_DUTY:     cfg_ff.slow_duty           <= pwdata[DUTY_W-1:0];
            REG_RIGHT_NORMAL:  cfg_ff.right_normal_duty   <= pwdata[DUTY_W-1:0];
            REG_LEFT_NORMAL:   cfg_ff.left_normal_duty    <= pwdata[DUTY_W-1:0];
            REG_BLACK_THRESH:  cfg_ff.black_threshold     <= pwdata[SENSE_W-1:0];
            REG_STRAIGHT:      cfg_ff.straight_ticks      <= pwdata[CTICK_W-1:0];
            REG_TURN:          cfg_ff.turn_ticks          <= pwdata[CTICK_W-1:0];
            REG_LONG_STRAIGHT: cfg_ff.long_straight_ticks <= pwdata[CTICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FAST_DUTY:     prdata = CSR_DW'(cfg_ff.fast_duty);
         REG_SLOW_DUTY:     prdata = CSR_DW'(cfg_ff.slow_duty);
         REG_RIGHT_NORMAL:  prdata = CSR_DW'(cfg_ff.right_normal_duty);
         REG_LEFT_NORMAL:   prdata = CSR_DW'(cfg_ff.left_normal_duty);
         REG_BLACK_THRESH:  prdata = CSR_DW'(cfg_ff.black_threshold);
         REG_STRAIGHT:      prdata = CSR_DW'(cfg_ff.straight_ticks);
         REG_TURN:          prdata = CSR_DW'(cfg_ff.turn_ticks);
         REG_LONG_STRAIGHT: prdata = CSR_DW'(cfg_ff.long_straight_ticks);
         default:           prdata = '0;
      endcase
   end

endmodule

// File: src/lfos_core.sv
// ---------------------------------------------------------------------------
// lfos_core
// Drive decision and manoeuvre sequencer: holds the manoeuvre state and
// turns one registered item into at most one motor command per cycle.
// ---------------------------------------------------------------------------
module lfos_core #(
   parameter int TICK_WIDTH = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lfos_pkg::item_type   item,
   input  lfos_pkg::cfg_type    cfg,
   output logic                 res_valid,
   output lfos_pkg::result_type res
);
   import lfos_pkg::*;

   localparam int LEN_W = (TICK_WIDTH > CTICK_W) ? TICK_WIDTH : CTICK_W;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'((64'd1 << TICK_WIDTH) - 64'd1);

   ctl_state_type         state_ff, state_in;
   logic                  first_ff, first_in;
   logic [2:0]            phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;

   logic [CTICK_W-1:0]    raw_len;
   logic [LEN_W-1:0]      wide_len;
   logic [TICK_WIDTH-1:0] phase_len;
   logic [TICK_WIDTH-1:0] tick_inc;
   logic                  phase_done;
   logic                  right_dark, left_dark, right_light, left_light;
   logic [3:0]            drive;

   // phase length, raised to at least one tick and capped at the tick counter's maximum
   always_comb begin
      unique case (phase_ff)
         PH_BACKUP:
            raw_len = (cfg.straight_ticks < CTICK_W'(2)) ? CTICK_W'(1)
                    : {1'b0, cfg.straight_ticks[CTICK_W-1:1]};
         PH_TURN_R1, PH_TURN_L1:
            raw_len = (cfg.turn_ticks == '0) ? CTICK_W'(1) : cfg.turn_ticks;
         PH_STRAIGHT1:
            raw_len = (cfg.straight_ticks == '0) ? CTICK_W'(1) : cfg.straight_ticks;
         PH_LONG:
            raw_len = (cfg.long_straight_ticks == '0) ? CTICK_W'(1)
                    : cfg.long_straight_ticks;
         PH_STRAIGHT2:
            raw_len = (cfg.straight_ticks <= STRAIGHT_TRIM) ? CTICK_W'(1)
                    : cfg.straight_ticks - STRAIGHT_TRIM;
         default:
            raw_len = (cfg.turn_ticks <= TURN_TRIM) ? CTICK_W'(1)
                    : cfg.turn_ticks - TURN_TRIM;
      endcase
      wide_len  = LEN_W'(raw_len);
      phase_len = (wide_len > LEN_MAX) ? LEN_MAX[TICK_WIDTH-1:0]
                                       : wide_len[TICK_WIDTH-1:0];
   end

   assign tick_inc   = (tick_ff != '1) ? tick_ff + TICK_WIDTH'(1) : tick_ff;
   assign phase_done = (tick_inc >= phase_len);

   // next state
   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      unique case (item.mode)
         MODE_TICK: begin
            if (state_ff == ST_MANEUVER) begin
               if (!phase_done) begin
                  tick_in = tick_inc;
               end else begin
                  tick_in = '0;
                  if (phase_ff == PH_TURN_R2) begin
                     state_in = ST_IDLE;
                     phase_in = PH_BACKUP;
                  end else begin
                     phase_in = phase_ff + 3'd1;
                  end
               end
            end
         end
         MODE_BUMP: begin
            if (state_ff == ST_IDLE) begin
               if (first_ff) begin
                  first_in = 1'b0;
               end else begin
                  state_in = ST_MANEUVER;
                  phase_in = PH_BACKUP;
                  tick_in  = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign right_dark  = item.right_sensor_count > cfg.black_threshold;
   assign left_dark   = item.left_sensor_count  > cfg.black_threshold;
   assign right_light = item.right_sensor_count < cfg.black_threshold;
   assign left_light  = item.left_sensor_count  < cfg.black_threshold;
   assign drive       = phase_drive(phase_in);

   // outputs
   always_comb begin
      res_valid           = 1'b0;
      res.right_duty      = cfg.right_normal_duty;
      res.left_duty       = cfg.left_normal_duty;
      res.right_reverse   = drive[3];
      res.left_reverse    = drive[2];
      res.led_color       = drive[1:0];
      res.maneuver_active = 1'b1;
      res.phase           = phase_in;
      unique case (item.mode)
         MODE_LINE: begin
            res_valid           = (state_ff == ST_IDLE);
            res.right_reverse   = 1'b0;
            res.left_reverse    = 1'b0;
            res.maneuver_active = 1'b0;
            res.phase           = PH_BACKUP;
            priority if (right_dark && left_light) begin
               res.right_duty = cfg.fast_duty;
               res.left_duty  = cfg.slow_duty;
               res.led_color  = LED_RED;
            end else if (left_dark && right_light) begin
               res.right_duty = cfg.slow_duty;
               res.left_duty  = cfg.fast_duty;
               res.led_color  = LED_GREEN;
            end else begin
               res.led_color  = LED_BLUE;
            end
         end
         MODE_TICK: begin
            res_valid = (state_ff == ST_MANEUVER) && phase_done;
            if (state_in == ST_IDLE) begin
               res.right_duty      = '0;
               res.left_duty       = '0;
               res.right_reverse   = 1'b0;
               res.left_reverse    = 1'b0;
               res.led_color       = LED_OFF;
               res.maneuver_active = 1'b0;
            end
         end
         MODE_BUMP: begin
            res_valid = (state_ff == ST_IDLE) && !first_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b1;
         phase_ff <= PH_BACKUP;
         tick_ff  <= '0;
      end else if (step) begin
         state_ff <= state_in;
         first_ff <= first_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

// File: src/line_follow_obstacle_sequencer.sv
// ---------------------------------------------------------------------------
// line_follow_obstacle_sequencer
// Line-follow drive controller with an eight-phase obstacle maneuver.
// ---------------------------------------------------------------------------
// Usage: items enter on the req_ channel (mode, right and left sensor
// counts); a line sample, a left encoder tick or a bump event. Each item
// gives zero or one motor command on the rsp_ channel, in item order.
// Line samples while idle always give a command; a bump starts the
// maneuver (the first bump after reset is dropped); ticks step it and a
// command appears on each phase change and at its end.
// An item is registered at acceptance and its command is loaded into the
// output register when it advances. Throughput is one item per cycle
// while the receiver keeps up: the input register and the output register
// each hold one transaction, and the single decision stage between them
// sets the rate. When the receiver stalls, the output register holds its
// command and the input register holds the next item; req_ready drops
// only when both are full. Reset clears both valid flags and the maneuver
// state and loads the register defaults. Configuration goes through the
// APB port only while idle, a user rule the block does not enforce.
// ---------------------------------------------------------------------------
module line_follow_obstacle_sequencer #(
   parameter int TICK_WIDTH = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [lfos_pkg::SENSE_W-1:0] req_right_sensor_count,
   input  logic [lfos_pkg::SENSE_W-1:0] req_left_sensor_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lfos_pkg::DUTY_W-1:0]  rsp_right_duty,
   output logic [lfos_pkg::DUTY_W-1:0]  rsp_left_duty,
   output logic                         rsp_right_reverse,
   output logic                         rsp_left_reverse,
   output logic [1:0]                   rsp_led_color,
   output logic                         rsp_maneuver_active,
   output logic [2:0]                   rsp_phase,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lfos_pkg::CSR_AW-1:0]  paddr,
   input  logic [lfos_pkg::CSR_DW-1:0]  pwdata,
   output logic [lfos_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import lfos_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   logic       advance;
   logic       res_valid;
   result_type res;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   lfos_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.mode               <= req_mode;
         item_ff.right_sensor_count <= req_right_sensor_count;
         item_ff.left_sensor_count  <= req_left_sensor_count;
      end
   end

   lfos_core #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_right_duty      = rsp_ff.right_duty;
   assign rsp_left_duty       = rsp_ff.left_duty;
   assign rsp_right_reverse   = rsp_ff.right_reverse;
   assign rsp_left_reverse    = rsp_ff.left_reverse;
   assign rsp_led_color       = rsp_ff.led_color;
   assign rsp_maneuver_active = rsp_ff.maneuver_active;
   assign rsp_phase           = rsp_ff.phase;

   // commands outside the maneuver always report phase zero
   a_idle_phase : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_maneuver_active |-> rsp_phase == PH_BACKUP)
      else $error("idle command with nonzero phase");

   // straight phases and back-up drive both wheels the same way
   a_led_off_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_maneuver_active && rsp_led_color == LED_OFF
      |-> rsp_right_reverse == rsp_left_reverse)
      else $error("led off phase with one wheel reversed");

   // a held item is not dropped while the output is blocked
   a_item_hold : assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("stalled item lost");

   // with both registers full and the receiver stalled the input side must be stalled
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while pipeline full");

endmodule

// File: tb/tb_line_follow_obstacle_sequencer.sv
// ---------------------------------------------------------------------------
// tb_line_follow_obstacle_sequencer
// Self-checking bench for the line-follow drive controller. A scoreboard
// class tracks the drive state and the register values, predicts the motor
// command for each accepted transaction and compares the commands in order.
// A short directed run covers threshold edges, the swallowed first bump and
// the length clamps. Random runs then sweep several register settings with
// random gaps on both sides bar one calm run, and one long receiver stall.
// ---------------------------------------------------------------------------
module tb_line_follow_obstacle_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import lfos_pkg::*;

   localparam int TICK_W     = 12;
   localparam int TICK_TOP   = (1 << TICK_W) - 1;
   localparam int QUIET_MAX  = 3000;
   localparam int HOLD_LEN   = 300;
   localparam int RUN_ITEMS  = 140;

   class motor_cmd_scoreboard;
      cfg_type           cfg;
      logic              first_bump_pending;
      logic              avoiding;
      logic [2:0]        leg;
      logic [TICK_W-1:0] leg_ticks;
      result_type        pending_cmds[$];
      int                errors;
      int                items_seen;
      int                cmds_seen;
      int                avoid_done;

      function new();
         cfg.fast_duty           = 16'd300;
         cfg.slow_duty           = 16'd100;
         cfg.right_normal_duty   = 16'd165;
         cfg.left_normal_duty    = 16'd160;
         cfg.black_threshold     = 24'd1000;
         cfg.straight_ticks      = 12'd500;
         cfg.turn_ticks          = 12'd190;
         cfg.long_straight_ticks = 12'd1000;
         first_bump_pending = 1'b1;
         avoiding   = 1'b0;
         leg        = PH_BACKUP;
         leg_ticks  = '0;
         errors     = 0;
         items_seen = 0;
         cmds_seen  = 0;
         avoid_done = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_FAST_DUTY:     cfg.fast_duty           = v[DUTY_W-1:0];
            REG_SLOW_DUTY:     cfg.slow_duty           = v[DUTY_W-1:0];
            REG_RIGHT_NORMAL:  cfg.right_normal_duty   = v[DUTY_W-1:0];
            REG_LEFT_NORMAL:   cfg.left_normal_duty    = v[DUTY_W-1:0];
            REG_BLACK_THRESH:  cfg.black_threshold     = v[SENSE_W-1:0];
            REG_STRAIGHT:      cfg.straight_ticks      = v[CTICK_W-1:0];
            REG_TURN:          cfg.turn_ticks          = v[CTICK_W-1:0];
            REG_LONG_STRAIGHT: cfg.long_straight_ticks = v[CTICK_W-1:0];
            default: ;
         endcase
      endfunction

      function int leg_length(logic [2:0] p);
         int s;
         int t;
         int n;
         s = int'(cfg.straight_ticks);
         t = int'(cfg.turn_ticks);
         case (p)
            PH_BACKUP:              n = s / 2;
            PH_TURN_R1, PH_TURN_L1: n = t;
            PH_STRAIGHT1:           n = s;
            PH_LONG:                n = int'(cfg.long_straight_ticks);
            PH_STRAIGHT2:           n = s - int'(STRAIGHT_TRIM);
            default:                n = t - int'(TURN_TRIM);
         endcase
         if (n < 1) n = 1;
         if (n > TICK_TOP) n = TICK_TOP;
         return n;
      endfunction

      function result_type leg_cmd(logic [2:0] p);
         result_type c;
         c.right_duty      = cfg.right_normal_duty;
         c.left_duty       = cfg.left_normal_duty;
         c.right_reverse   = 1'b0;
         c.left_reverse    = 1'b0;
         c.led_color       = LED_OFF;
         c.maneuver_active = 1'b1;
         c.phase           = p;
         case (p)
            PH_BACKUP: begin
               c.right_reverse = 1'b1;
               c.left_reverse  = 1'b1;
            end
            PH_TURN_R1, PH_TURN_R2: begin
               c.left_reverse = 1'b1;
               c.led_color    = LED_GREEN;
            end
            PH_TURN_L1, PH_TURN_L2: begin
               c.right_reverse = 1'b1;
               c.led_color     = LED_RED;
            end
            default: ;
         endcase
         return c;
      endfunction

      function void predict_cmd(item_type it);
         result_type         c;
         logic [SENSE_W-1:0] thr;
         logic               hit;
         items_seen++;
         hit = 1'b0;
         c   = '0;
         thr = cfg.black_threshold;
         case (it.mode)
            MODE_LINE: begin
               if (!avoiding) begin
                  hit = 1'b1;
                  if (it.right_sensor_count > thr && it.left_sensor_count < thr) begin
                     c.right_duty = cfg.fast_duty;
                     c.left_duty  = cfg.slow_duty;
                     c.led_color  = LED_RED;
                  end else if (it.left_sensor_count > thr && it.right_sensor_count < thr) begin
                     c.right_duty = cfg.slow_duty;
                     c.left_duty  = cfg.fast_duty;
                     c.led_color  = LED_GREEN;
                  end else begin
                     c.right_duty = cfg.right_normal_duty;
                     c.left_duty  = cfg.left_normal_duty;
                     c.led_color  = LED_BLUE;
                  end
               end
            end
            MODE_TICK: begin
               if (avoiding) begin
                  if (leg_ticks != '1) leg_ticks++;
                  if (int'(leg_ticks) >= leg_length(leg)) begin
                     leg_ticks = '0;
                     hit = 1'b1;
                     if (leg == PH_TURN_R2) begin
                        // last leg done: all-zero command, back to line following
                        avoiding = 1'b0;
                        leg      = PH_BACKUP;
                        avoid_done++;
                     end else begin
                        leg++;
                        c = leg_cmd(leg);
                     end
                  end
               end
            end
            MODE_BUMP: begin
               if (!avoiding) begin
                  if (first_bump_pending) begin
                     first_bump_pending = 1'b0;
                  end else begin
                     avoiding  = 1'b1;
                     leg       = PH_BACKUP;
                     leg_ticks = '0;
                     hit       = 1'b1;
                     c         = leg_cmd(PH_BACKUP);
                  end
               end
            end
            default: ;
         endcase
         if (hit) pending_cmds.push_back(c);
      endfunction

      function void cmp_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_cmd(result_type got);
         result_type want;
         cmds_seen++;
         if (pending_cmds.size() == 0) begin
            $error("motor command %h arrived with nothing expected", got);
            errors++;
            return;
         end
         want = pending_cmds.pop_front();
         cmp_field("right_duty", want.right_duty, got.right_duty);
         cmp_field("left_duty", want.left_duty, got.left_duty);
         cmp_field("right_reverse", want.right_reverse, got.right_reverse);
         cmp_field("left_reverse", want.left_reverse, got.left_reverse);
         cmp_field("led_color", want.led_color, got.led_color);
         cmp_field("maneuver_active", want.maneuver_active, got.maneuver_active);
         cmp_field("phase", want.phase, got.phase);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_NONE;
   logic [SENSE_W-1:0] req_right_sensor_count = '0;
   logic [SENSE_W-1:0] req_left_sensor_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [DUTY_W-1:0]  rsp_right_duty;
   logic [DUTY_W-1:0]  rsp_left_duty;
   logic               rsp_right_reverse;
   logic               rsp_left_reverse;
   logic [1:0]         rsp_led_color;
   logic               rsp_maneuver_active;
   logic [2:0]         rsp_phase;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_AW-1:0]  paddr = '0;
   logic [CSR_DW-1:0]  pwdata = '0;
   logic [CSR_DW-1:0]  prdata;
   logic               pready;

   motor_cmd_scoreboard cmd_board = new();

   bit         calm = 1'b0;
   bit         hold_request = 1'b0;
   bit         hold_done = 1'b0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   int         settings_used = 0;
   item_type   seen_item;
   result_type seen_cmd;

   line_follow_obstacle_sequencer #(.TICK_WIDTH(TICK_W)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_right_sensor_count (req_right_sensor_count),
      .req_left_sensor_count  (req_left_sensor_count),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_right_duty         (rsp_right_duty),
      .rsp_left_duty          (rsp_left_duty),
      .rsp_right_reverse      (rsp_right_reverse),
      .rsp_left_reverse       (rsp_left_reverse),
      .rsp_led_color          (rsp_led_color),
      .rsp_maneuver_active    (rsp_maneuver_active),
      .rsp_phase              (rsp_phase),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // accepted input transaction feeds the prediction
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         seen_item.mode               = req_mode;
         seen_item.right_sensor_count = req_right_sensor_count;
         seen_item.left_sensor_count  = req_left_sensor_count;
         cmd_board.predict_cmd(seen_item);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_cmd.right_duty      = rsp_right_duty;
         seen_cmd.left_duty       = rsp_left_duty;
         seen_cmd.right_reverse   = rsp_right_reverse;
         seen_cmd.left_reverse    = rsp_left_reverse;
         seen_cmd.led_color       = rsp_led_color;
         seen_cmd.maneuver_active = rsp_maneuver_active;
         seen_cmd.phase           = rsp_phase;
         cmd_board.check_cmd(seen_cmd);
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 22);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
         $display("timeout after %0d cycles without a transaction", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] mode, logic [SENSE_W-1:0] rs, logic [SENSE_W-1:0] ls);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_mode               <= mode;
      req_right_sensor_count <= rs;
      req_left_sensor_count  <= ls;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait until the block has nothing in flight
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cmd_board.pending_cmds.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [CSR_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cmd_board.write_reg(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // random bits above the register width must be dropped by the block
   function automatic logic [CSR_DW-1:0] with_junk(logic [CSR_DW-1:0] v, int w);
      logic [CSR_DW-1:0] j;
      j = $urandom();
      return (j << w) | (v & ((32'd1 << w) - 1));
   endfunction

   task automatic write_setting(int fast, int slow, int rn, int ln, int thr,
                                int st, int tt, int lt);
      csr_write(REG_FAST_DUTY, with_junk(fast, DUTY_W));
      csr_write(REG_SLOW_DUTY, with_junk(slow, DUTY_W));
      csr_write(REG_RIGHT_NORMAL, with_junk(rn, DUTY_W));
      csr_write(REG_LEFT_NORMAL, with_junk(ln, DUTY_W));
      csr_write(REG_BLACK_THRESH, with_junk(thr, SENSE_W));
      csr_write(REG_STRAIGHT, with_junk(st, CTICK_W));
      csr_write(REG_TURN, with_junk(tt, CTICK_W));
      csr_write(REG_LONG_STRAIGHT, with_junk(lt, CTICK_W));
      settings_used++;
   endtask

   // sensor counts clustered around the threshold to hit the strict compares
   function automatic logic [SENSE_W-1:0] pick_count();
      logic [SENSE_W-1:0] thr;
      thr = cmd_board.cfg.black_threshold;
      case ($urandom_range(5))
         0: return thr;
         1: return thr + 1'b1;
         2: return thr - 1'b1;
         3: return $urandom_range(1) ? '1 : '0;
         default: return SENSE_W'($urandom());
      endcase
   endfunction

   task automatic send_random();
      int         r;
      logic [1:0] m;
      r = $urandom_range(99);
      if (cmd_board.avoiding) begin
         if (r < 80) m = MODE_TICK;
         else if (r < 88) m = MODE_LINE;
         else if (r < 95) m = MODE_BUMP;
         else m = MODE_NONE;
      end else begin
         if (r < 55) m = MODE_LINE;
         else if (r < 80) m = MODE_BUMP;
         else if (r < 92) m = MODE_TICK;
         else m = MODE_NONE;
      end
      send_item(m, pick_count(), pick_count());
   endtask

   initial begin
      int n_items;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: threshold edges at reset defaults
      send_item(MODE_LINE, 24'd0, 24'd0);
      send_item(MODE_LINE, '1, 24'd0);
      send_item(MODE_LINE, 24'd0, '1);
      send_item(MODE_LINE, 24'd1001, 24'd999);
      send_item(MODE_LINE, 24'd999, 24'd1001);
      send_item(MODE_LINE, 24'd1000, 24'd0);
      send_item(MODE_LINE, 24'd1001, 24'd1000);
      send_item(MODE_LINE, '1, '1);
      send_item(MODE_NONE, SENSE_W'($urandom()), SENSE_W'($urandom()));
      send_item(MODE_TICK, 24'd0, 24'd0);
      // first bump is swallowed, the second starts the manoeuvre
      send_item(MODE_BUMP, 24'd0, 24'd0);
      send_item(MODE_BUMP, 24'd0, 24'd0);
      send_item(MODE_LINE, '1, 24'd0);
      send_item(MODE_BUMP, 24'd0, 24'd0);
      send_item(MODE_TICK, 24'd0, 24'd0);
      drain();
      // lengths that clamp to one tick, then walk the rest of the manoeuvre
      write_setting(300, 100, 165, 160, 1000, 1, 0, 0);
      repeat (8) send_item(MODE_TICK, 24'd0, 24'd0);
      drain();

      for (int run = 0; run < 10; run++) begin
         n_items = RUN_ITEMS;
         case (run)
            0: write_setting(0, 0, 0, 0, 0, 0, 0, 0);
            1: write_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                             12'hFFF, 12'hFFF, 12'hFFF);
            2: begin
               write_setting($urandom_range(65535), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(3000), 100, 26, 1);
               n_items = 2 * RUN_ITEMS;
               calm    = 1'b1;
            end
            default: begin
               write_setting($urandom_range(65535), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(1) ? $urandom_range(3000)
                                               : $urandom_range(24'hFFFFFF),
                             $urandom_range(30), $urandom_range(30),
                             $urandom_range(12));
               if (run == 3) hold_request = 1'b1;
            end
         endcase
         repeat (n_items) send_random();
         drain();
         calm = 1'b0;
      end

      $display("run covered %0d transactions in, %0d motor commands out, %0d full manoeuvres",
               cmd_board.items_seen, cmd_board.cmds_seen, cmd_board.avoid_done);
      $display("across %0d register settings incl. all-zero and all-ones, with a long stall",
               settings_used);
      if (cmd_board.errors == 0 && cmd_board.pending_cmds.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: line_follow_obstacle_sequencer.f
src/lfos_pkg.sv
src/lfos_csr.sv
src/lfos_core.sv
src/line_follow_obstacle_sequencer.sv
tb/tb_line_follow_obstacle_sequencer.sv
